FILE: sv/bvg_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage gauge package
// Shared widths, constants, charge curve and controller command types.
// ----------------------------------------------------------------------------
package bvg_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SCALE_W  = 13;
  localparam int BATT_W   = 15;
  localparam int PCT_W    = 7;
  localparam int VOLT_W   = 19;
  localparam int PROD_W   = 25;
  localparam int DVS_W    = 13;
  localparam int QUO_W    = 5;
  localparam int BIT_W    = 3;
  localparam int KNEES    = 6;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 13'd4096;

  // Plausible window on avg * scale: 2500 mV and 4500 mV times 1024.
  localparam logic [PROD_W-1:0] PLAUS_LO = 25'd2560000;
  localparam logic [PROD_W-1:0] PLAUS_HI = 25'd4608000;

  // Charge curve knees in 1/16 mV and their charge levels.
  localparam logic [VOLT_W-1:0] KNEE_V [KNEES] = '{
    19'd54400, 19'd57600, 19'd59200, 19'd60800, 19'd63200, 19'd67200
  };
  localparam logic [PCT_W-1:0] KNEE_PCT [KNEES] = '{
    7'd0, 7'd10, 7'd25, 7'd50, 7'd75, 7'd100
  };
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [BIT_W-1:0] PCT_TOP_BIT = 3'd4;

  typedef struct packed {
    logic             accept;
    logic             avg_div;
    logic             div_step;
    logic [BIT_W-1:0] div_bit;
    logic             mul;
    logic             filt;
    logic             num;
    logic             pct_load;
    logic             out_load;
  } bvg_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } bvg_stat_t;

endpackage

FILE: sv/bvg_ctrl.sv
// ----------------------------------------------------------------------------
// Battery voltage gauge controller
// Sequences sample accumulation, the two divisions, scaling, smoothing and
// the result hand-off.
// ----------------------------------------------------------------------------
module bvg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  bvg_pkg::bvg_stat_t stat,
  output bvg_pkg::bvg_cmd_t  cmd
);
  import bvg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV_A = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_FILT  = 3'd3;
  localparam logic [2:0] S_NUM   = 3'd4;
  localparam logic [2:0] S_PLOAD = 3'd5;
  localparam logic [2:0] S_DIV_P = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]       state, state_next;
  logic [BIT_W-1:0] bit_idx, bit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.div_bit  = bit_idx;
    case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && stat.last) begin
          state_next = S_DIV_A;
        end
      end
      S_DIV_A: begin
        cmd.avg_div = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FILT;
      end
      S_FILT: begin
        cmd.filt   = 1'b1;
        state_next = S_NUM;
      end
      S_NUM: begin
        cmd.num    = 1'b1;
        state_next = S_PLOAD;
      end
      S_PLOAD: begin
        cmd.pct_load = 1'b1;
        bit_idx_next = PCT_TOP_BIT;
        state_next   = S_DIV_P;
      end
      S_DIV_P: begin
        cmd.div_step = 1'b1;
        if (bit_idx == '0) begin
          state_next = S_OUT;
        end else begin
          bit_idx_next = bit_idx - 1'b1;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/bvg_dpath.sv
// ----------------------------------------------------------------------------
// Battery voltage gauge datapath
// Sample accumulator, reciprocal-multiply average, trim multiplier, smoothing
// filter, charge curve lookup with a restoring divider and output register.
// ----------------------------------------------------------------------------
module bvg_dpath #(
  parameter int SAMPLES_PER_READING = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bvg_pkg::bvg_cmd_t             cmd,
  output bvg_pkg::bvg_stat_t            stat,
  input  logic [bvg_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          cfg_wen,
  input  logic [bvg_pkg::SCALE_W-1:0]   cfg_wdata,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [39:0]                   m_tdata,
  output logic                          m_tuser
);
  import bvg_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_READING);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int REM_W = (SUM_W > 18) ? SUM_W : 18;
  localparam int HALF  = SAMPLES_PER_READING / 2;

  // The rounded total stays below 2^SUM_W, so a reciprocal with
  // SUM_W + CNT_W fraction bits gives the exact quotient.
  localparam int RECIP_SH = SUM_W + CNT_W;
  localparam int RECIP_W  = SUM_W + 2;
  localparam int MULT_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
    ((1 << RECIP_SH) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

  logic [SCALE_W-1:0]  scale;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    count;
  logic [REM_W-1:0]    rem;
  logic [DVS_W-1:0]    dvs;
  logic [QUO_W-1:0]    quo;
  logic [SAMPLE_W-1:0] avg;
  logic [PROD_W-1:0]   prod;
  logic [VOLT_W-1:0]   filtv;
  logic                vvalid;
  logic [PCT_W-1:0]    pct_base;
  logic [16:0]         num;
  logic [11:0]         den;

  logic                last;
  logic [MULT_W-1:0]   avg_prod;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    dvs_sh;
  logic                plaus;
  logic [VOLT_W-1:0]   meas;
  logic [20:0]         smooth;
  logic [19:0]         bsum;
  logic [BATT_W-1:0]   bmv;
  logic [2:0]          seg;
  logic [VOLT_W-1:0]   lo_v;
  logic [11:0]         diff;
  logic [PCT_W-1:0]    dp_full;
  logic [4:0]          dp;
  logic [11:0]         seg_den;
  logic [PCT_W-1:0]    base_next;
  logic                interp;
  logic [PCT_W-1:0]    pct;

  assign last          = (count == CNT_W'(SAMPLES_PER_READING - 1));
  assign stat.last     = last;
  assign stat.out_free = !m_tvalid || m_tready;

  assign avg_prod = MULT_W'(rem[SUM_W-1:0]) * MULT_W'(RECIP);

  assign rem_sh = rem >> cmd.div_bit;
  assign dvs_sh = REM_W'(dvs) << cmd.div_bit;

  assign plaus  = (prod >= PLAUS_LO) && (prod <= PLAUS_HI);
  assign meas   = VOLT_W'((prod + 25'd32) >> 6);
  assign smooth = {2'b00, filtv} + {1'b0, filtv, 1'b0} + {2'b00, meas} + 21'd2;
  assign bsum   = {1'b0, filtv} + 20'd8;
  assign bmv    = bsum[18:4];
  assign pct    = pct_base + PCT_W'(quo);

  always_comb begin
    seg = 3'd5;
    for (int i = KNEES - 1; i >= 1; i--) begin
      if (filtv <= KNEE_V[i]) begin
        seg = 3'(i);
      end
    end
    lo_v    = KNEE_V[seg - 3'd1];
    diff    = 12'(filtv - lo_v);
    dp_full = KNEE_PCT[seg] - KNEE_PCT[seg - 3'd1];
    dp      = dp_full[4:0];
    seg_den = 12'(KNEE_V[seg] - lo_v);
    if (!vvalid || filtv <= KNEE_V[0]) begin
      interp    = 1'b0;
      base_next = '0;
    end else if (filtv > KNEE_V[KNEES-1]) begin
      interp    = 1'b0;
      base_next = PCT_FULL;
    end else begin
      interp    = 1'b1;
      base_next = KNEE_PCT[seg - 3'd1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale    <= SCALE_RESET;
      sum      <= '0;
      count    <= '0;
      filtv    <= '0;
      vvalid   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (last) begin
          sum   <= '0;
          count <= '0;
        end else begin
          sum   <= sum + SUM_W'(sample);
          count <= count + 1'b1;
        end
      end
      if (cmd.filt) begin
        filtv  <= (plaus && vvalid) ? smooth[20:2] : meas;
        vvalid <= plaus;
      end
      if (cfg_wen) begin
        scale  <= cfg_wdata;
        vvalid <= 1'b0;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && last) begin
      rem <= REM_W'(sum) + REM_W'(sample) + REM_W'(HALF);
    end else if (cmd.pct_load) begin
      rem <= REM_W'({num, 1'b0}) + REM_W'(den);
      dvs <= {den, 1'b0};
      quo <= '0;
    end else if (cmd.div_step && (rem_sh >= REM_W'(dvs))) begin
      rem              <= rem - dvs_sh;
      quo[cmd.div_bit] <= 1'b1;
    end
    if (cmd.avg_div) begin
      avg <= avg_prod[RECIP_SH +: SAMPLE_W];
    end
    if (cmd.mul) begin
      prod <= PROD_W'(avg) * PROD_W'(scale);
    end
    if (cmd.num) begin
      pct_base <= base_next;
      num      <= interp ? 17'(diff) * 17'(dp) : '0;
      den      <= interp ? seg_den : 12'd1;
    end
    if (cmd.out_load) begin
      m_tdata <= {6'b0, pct, bmv, avg};
      m_tuser <= vvalid;
    end
  end

endmodule

FILE: sv/battery_voltage_gauge_top.sv
// ----------------------------------------------------------------------------
// Battery voltage gauge top level
// Every sample of a reading is accumulated; the final one, once accepted,
// starts one average step, 4 scaling/filter steps, 5 charge-divide steps
// and the output load. No new sample is accepted until the output load,
// which waits while the output register holds a result not yet taken.
// Reset is synchronous; it restores a trim of 4096, clears the accumulator,
// the filter and its validity.
// ----------------------------------------------------------------------------
module battery_voltage_gauge_top #(
  parameter int SAMPLES_PER_READING = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] adc_sample_mv
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [11:0] adc_average_mv, [26:12] battery_mv,
                                 // [33:27] charge_percent
  output logic        m_tuser,   // [0] reading_valid
  input  logic        cfg_wen,
  input  logic [12:0] cfg_wdata
);
  import bvg_pkg::*;

  bvg_cmd_t  cmd;
  bvg_stat_t stat;

  bvg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bvg_dpath #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sample    (s_tdata[SAMPLE_W-1:0]),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // An implausible reading reports no charge.
  a_pct_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[33:27] == 7'd0)
    else $error("charge reported for an implausible reading");

  // A valid reading never reports more than full charge.
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[33:27] <= 7'd100)
    else $error("charge above full");

  // Smoothing of plausible voltages stays inside the plausible window.
  a_volt_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[26:12] >= 15'd2500 && m_tdata[26:12] <= 15'd4500)
    else $error("valid reading outside the plausible voltage window");

  // The input side stalls while a final sample is being processed.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && stat.last |=> !s_tready)
    else $error("input accepted while a reading is in progress");

endmodule

FILE: tb/sv/tb_battery_voltage_gauge_top.sv
// ----------------------------------------------------------------------------
// Battery voltage gauge testbench
// Streams ADC samples into the gauge and checks every reading it returns
// against an in-bench model of the averaging, trim scaling, smoothing and
// charge curve, or typed values. A directed table covers boundaries and trim
// corner cases; random readings run at several trims with random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_battery_voltage_gauge_top;
  import bvg_pkg::*;

  localparam int READING_LEN = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int DIR_N = 20;

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_mv;
    logic [BATT_W-1:0]   batt_mv;
    logic [PCT_W-1:0]    charge;
    logic                valid;
  } reading_t;

  typedef struct packed {
    logic                scale_wr;
    logic                mid_wr;
    logic [SCALE_W-1:0]  scale;
    logic [SAMPLE_W-1:0] samp_a;
    logic [SAMPLE_W-1:0] samp_b;
    logic                typed;
    reading_t            want;
  } dir_row_t;

  localparam reading_t NO_READING = '0;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{1'b0, 1'b0, 13'd0,    12'd0,    12'd0,    1'b1, '{12'd0, 15'd0, 7'd0, 1'b0}},
    '{1'b0, 1'b0, 13'd0,    12'd4095, 12'd4095, 1'b1, '{12'd4095, 15'd16380, 7'd0, 1'b0}},
    '{1'b0, 1'b0, 13'd0,    12'd1000, 12'd1000, 1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd1000, 12'd1001, 1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd850,  12'd850,  1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd0,    12'd4095, 1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd625,  12'd625,  1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd1125, 12'd1125, 1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd1126, 12'd1126, 1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd624,  12'd624,  1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd1050, 12'd1050, 1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd1060, 12'd1060, 1'b0, NO_READING},
    '{1'b1, 1'b0, 13'd3277, 12'd1000, 12'd1000, 1'b0, NO_READING},
    '{1'b1, 1'b1, 13'd4915, 12'd900,  12'd900,  1'b0, NO_READING},
    '{1'b1, 1'b0, 13'd0,    12'd2000, 12'd2000, 1'b1, '{12'd2000, 15'd0, 7'd0, 1'b0}},
    '{1'b1, 1'b0, 13'd8191, 12'd4095, 12'd4095, 1'b1, '{12'd4095, 15'd32756, 7'd0, 1'b0}},
    '{1'b1, 1'b0, 13'd4096, 12'd925,  12'd925,  1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd950,  12'd950,  1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd988,  12'd988,  1'b0, NO_READING},
    '{1'b0, 1'b0, 13'd0,    12'd900,  12'd901,  1'b0, NO_READING}
  };

  localparam int unsigned CURVE_MV [6] = '{3400, 3600, 3700, 3800, 3950, 4200};
  localparam int unsigned CURVE_PCT [6] = '{0, 10, 25, 50, 75, 100};

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [15:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [39:0] m_tdata;
  logic m_tuser;
  logic cfg_wen;
  logic [12:0] cfg_wdata;

  int unsigned sum_mv;
  int unsigned samples_taken;
  int unsigned smoothed_v16;
  bit          smoothed_ok;
  int unsigned trim;
  reading_t    pending_readings [$];
  int          mismatch_count;
  bit          no_idle;

  battery_voltage_gauge_top #(
    .SAMPLES_PER_READING(READING_LEN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned charge_at(input int unsigned v16);
    int unsigned lo;
    int unsigned hi;
    int unsigned den;
    int unsigned num;
    if (v16 <= CURVE_MV[0] * 16) begin
      return 0;
    end
    for (int i = 1; i < 6; i++) begin
      hi = CURVE_MV[i] * 16;
      if (v16 <= hi) begin
        lo = CURVE_MV[i-1] * 16;
        den = hi - lo;
        num = (v16 - lo) * (CURVE_PCT[i] - CURVE_PCT[i-1]);
        return CURVE_PCT[i-1] + (2 * num + den) / (2 * den);
      end
    end
    return 100;
  endfunction

  function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] v, output bit fresh,
                                            output reading_t r);
    int unsigned avg;
    int unsigned prod;
    int unsigned meas;
    bit          plaus;
    fresh = 1'b0;
    r = '0;
    sum_mv += v;
    samples_taken++;
    if (samples_taken < READING_LEN) begin
      return;
    end
    avg = ((sum_mv + READING_LEN / 2) / READING_LEN) & 32'hFFF;
    sum_mv = 0;
    samples_taken = 0;
    prod = avg * trim;
    plaus = (prod >= 2500 * 1024) && (prod <= 4500 * 1024);
    meas = (prod + 32) >> 6;
    if (plaus && smoothed_ok) begin
      smoothed_v16 = (3 * smoothed_v16 + meas + 2) >> 2;
    end else begin
      smoothed_v16 = meas;
    end
    smoothed_v16 &= 32'h7FFFF;
    smoothed_ok = plaus;
    fresh = 1'b1;
    r.avg_mv = avg[SAMPLE_W-1:0];
    r.batt_mv = BATT_W'((smoothed_v16 + 8) >> 4);
    r.charge = smoothed_ok ? PCT_W'(charge_at(smoothed_v16)) : '0;
    r.valid = smoothed_ok;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit use_typed,
                             input reading_t typed);
    reading_t predicted;
    bit       fresh;
    if (!no_idle && $urandom_range(0, 99) < 9) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, v};
    do @(posedge clk); while (!s_tready);
    accumulate_sample(v, fresh, predicted);
    if (fresh) begin
      pending_readings.push_back(use_typed ? typed : predicted);
    end
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    trim = value;
    smoothed_ok = 1'b0;
  endtask

  task automatic send_reading(input logic [SCALE_W-1:0] scale);
    int lo;
    int hi;
    int center;
    int spread;
    int s;
    bit noise;
    center = 0;
    spread = 0;
    noise = (scale == 0) || ($urandom_range(0, 3) == 0);
    if (!noise) begin
      lo = (2560000 + int'(scale) - 1) / int'(scale);
      hi = 4608000 / int'(scale);
      if (hi > 4095) begin
        hi = 4095;
      end
      if (lo > hi) begin
        noise = 1'b1;
      end else begin
        center = $urandom_range(hi, lo);
        spread = $urandom_range(0, 24);
      end
    end
    for (int k = 0; k < READING_LEN; k++) begin
      if (noise) begin
        s = $urandom_range(0, 4095);
      end else begin
        s = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
      end
      send_sample(SAMPLE_W'(s), 1'b0, NO_READING);
    end
  endtask

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= 9);
  end

  always @(posedge clk) begin : reading_check
    reading_t got;
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.avg_mv = m_tdata[11:0];
      got.batt_mv = m_tdata[26:12];
      got.charge = m_tdata[33:27];
      got.valid = m_tuser;
      if (pending_readings.size() == 0) begin
        flag_mismatch("unexpected reading, adc_average_mv", got.avg_mv, 0);
      end else begin
        want = pending_readings.pop_front();
        if (got.avg_mv !== want.avg_mv) flag_mismatch("adc_average_mv", got.avg_mv, want.avg_mv);
        if (got.batt_mv !== want.batt_mv) flag_mismatch("battery_mv", got.batt_mv, want.batt_mv);
        if (got.charge !== want.charge) flag_mismatch("charge_percent", got.charge, want.charge);
        if (got.valid !== want.valid) flag_mismatch("reading_valid", got.valid, want.valid);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_row_t         row;
    logic [SCALE_W-1:0] scale;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    mismatch_count = 0;
    sum_mv = 0;
    samples_taken = 0;
    smoothed_v16 = 0;
    smoothed_ok = 1'b0;
    trim = SCALE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      row = DIR_ROWS[r];
      if (row.scale_wr && !row.mid_wr) begin
        write_scale(row.scale);
      end
      for (int k = 0; k < READING_LEN; k++) begin
        if (row.mid_wr && k == READING_LEN / 2) begin
          write_scale(row.scale);
        end
        send_sample((k % 2 == 0) ? row.samp_a : row.samp_b, row.typed, row.want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: scale = 13'd4096;
        1: scale = 13'd3277;
        2: scale = 13'd4915;
        4: scale = 13'd0;
        5: scale = 13'd8191;
        6: scale = SCALE_W'($urandom_range(0, 8191));
        default: scale = SCALE_W'($urandom_range(3277, 4915));
      endcase
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, READING_LEN - 1)) begin
          send_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'b0, NO_READING);
        end
      end
      no_idle = (p == 2);
      write_scale(scale);
      for (int n = 0; n < 6; n++) begin
        send_reading(scale);
      end
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
